[rtl/ntcdiv_pkg.sv]
// Shared types, constants and the resistance table of the NTC divider
// temperature block. No dependencies.
`default_nettype none

package ntcdiv_pkg;

   // field and register widths
   localparam int ADC_W    = 13;
   localparam int SUPPLY_W = 13;
   localparam int SERIES_W = 20;
   localparam int TEMP_W   = 15;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SERIES_W;

   // resistance table, tenths of an ohm
   localparam int TABLE_ENTRIES = 43;
   localparam int FULL_TABLE    = 43;
   localparam int USED_RAW      = (TABLE_ENTRIES < FULL_TABLE) ? TABLE_ENTRIES : FULL_TABLE;
   localparam int USED_ENTRIES  = (USED_RAW < 2) ? 2 : USED_RAW;
   localparam int RES_W         = 24;
   localparam int IDX_W         = $clog2(FULL_TABLE);

   // datapath widths
   localparam int RS10_W    = SERIES_W + 4;
   localparam int SUM_W     = RES_W + 1;
   localparam int MUL_A_W   = SUPPLY_W;
   localparam int MUL_B_W   = SUM_W;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int DIV_NUM_W = 37;
   localparam int DIV_DEN_W = 23;
   localparam int DIV_QUO_W = RES_W;
   localparam int DIV_STEP_W = $clog2(DIV_QUO_W + 1);
   localparam int DIV_SH_W  = $clog2(DIV_NUM_W + 1);
   localparam int INT_STEPS = 10;

   localparam logic [DIV_STEP_W-1:0] RES_STEPS_CODE = DIV_STEP_W'(DIV_QUO_W);
   localparam logic [DIV_STEP_W-1:0] INT_STEPS_CODE = DIV_STEP_W'(INT_STEPS);
   localparam logic [MUL_A_W-1:0]    INT_SCALE      = MUL_A_W'(1000);

   localparam logic signed [TEMP_W-1:0] FIRST_CENTI = TEMP_W'(-5500);
   localparam logic signed [TEMP_W-1:0] STEP_CENTI  = TEMP_W'(500);
   localparam logic signed [TEMP_W-1:0] TEMP_MIN    = TEMP_W'(-5500);
   localparam logic signed [TEMP_W-1:0] TEMP_MAX    = TEMP_W'(15500);

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ABOVE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BELOW = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERIES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER  = 2'd2;

   function automatic logic [RES_W-1:0] res_entry(input logic [IDX_W-1:0] idx);
      logic [RES_W-1:0] r;
      unique case (idx)
         6'd0:  r = 24'd9630000;
         6'd1:  r = 24'd6701000;
         6'd2:  r = 24'd4717000;
         6'd3:  r = 24'd3365000;
         6'd4:  r = 24'd2426000;
         6'd5:  r = 24'd1770000;
         6'd6:  r = 24'd1304000;
         6'd7:  r = 24'd970700;
         6'd8:  r = 24'd729300;
         6'd9:  r = 24'd553300;
         6'd10: r = 24'd423200;
         6'd11: r = 24'd326500;
         6'd12: r = 24'd253900;
         6'd13: r = 24'd199000;
         6'd14: r = 24'd157100;
         6'd15: r = 24'd124900;
         6'd16: r = 24'd100000;
         6'd17: r = 24'd80570;
         6'd18: r = 24'd65310;
         6'd19: r = 24'd53270;
         6'd20: r = 24'd43690;
         6'd21: r = 24'd36030;
         6'd22: r = 24'd29860;
         6'd23: r = 24'd24880;
         6'd24: r = 24'd20830;
         6'd25: r = 24'd17520;
         6'd26: r = 24'd14810;
         6'd27: r = 24'd12580;
         6'd28: r = 24'd10720;
         6'd29: r = 24'd9177;
         6'd30: r = 24'd7885;
         6'd31: r = 24'd6800;
         6'd32: r = 24'd5886;
         6'd33: r = 24'd5112;
         6'd34: r = 24'd4454;
         6'd35: r = 24'd3893;
         6'd36: r = 24'd3417;
         6'd37: r = 24'd3009;
         6'd38: r = 24'd2654;
         6'd39: r = 24'd2348;
         6'd40: r = 24'd2083;
         6'd41: r = 24'd1853;
         6'd42: r = 24'd1653;
         default: r = '0;
      endcase
      return r;
   endfunction

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(USED_ENTRIES - 1);
   localparam logic [RES_W-1:0] RES_FIRST = res_entry(IDX_W'(0));
   localparam logic [RES_W-1:0] RES_LAST  = res_entry(LAST_IDX);

   // register reset values
   localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = SUPPLY_W'(3000);
   localparam logic [RS10_W-1:0]   RS10_RESET   = RS10_W'(100000);
   localparam logic [SUM_W-1:0]    SUMF_RESET   = SUM_W'(RES_FIRST) + SUM_W'(RS10_RESET);
   localparam logic [SUM_W-1:0]    SUML_RESET   = SUM_W'(RES_LAST) + SUM_W'(RS10_RESET);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RC0,
      ST_RC1,
      ST_RC2,
      ST_RC3,
      ST_RC4,
      ST_RES_DIV,
      ST_RES_WAIT,
      ST_WALK0,
      ST_WALK,
      ST_INT_MUL,
      ST_INT_DIV,
      ST_INT_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
      logic [DIV_NUM_W-1:0]  num;
      logic [DIV_DEN_W-1:0]  den;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_QUO_W-1:0] quo;
   } div_rsp_type;

endpackage

`default_nettype wire

[rtl/ntcdiv_ifs.sv]
// Channel interfaces: reading in, result out, register writes.
// Depends on ntcdiv_pkg.
`default_nettype none

interface ntcdiv_req_if;
   logic                         valid;
   logic                         ready;
   logic [ntcdiv_pkg::ADC_W-1:0] adc_mv;
   modport source (output valid, output adc_mv, input ready);
   modport sink   (input valid, input adc_mv, output ready);
endinterface

interface ntcdiv_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ntcdiv_pkg::TEMP_W-1:0]   temp_centi_c;
   logic        [ntcdiv_pkg::STATUS_W-1:0] status;
   modport source (output valid, output temp_centi_c, output status, input ready);
   modport sink   (input valid, input temp_centi_c, input status, output ready);
endinterface

interface ntcdiv_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ntcdiv_pkg::CSR_IDX_W-1:0]  index;
   logic [ntcdiv_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/ntc_divider_lut_temperature.sv]
// Top level of the NTC divider temperature block: register file, control
// sequencer, shared multiplier, resistance ROM and serial divider.
// Depends on ntcdiv_pkg, ntcdiv_ifs, ntcdiv_rom, ntcdiv_div.
`default_nettype none

// One ADC beat in, one result beat out. A reading outside the table's end
// voltages is flagged after the range check. Otherwise an item goes through
// a 24-step division for the resistance, a walk through the resistance ROM
// at one entry per cycle until the bracketing interval is found (1 to 42
// entries), and a 10-step division for the interpolation. At the divider's
// end cases the resistance division is skipped. The next reading can be
// accepted in the same cycle as the result appears. The range check runs
// four products through one 13x25 multiplier. A new reading is taken while
// a finished result still waits in the output register.
module ntc_divider_lut_temperature (
   input  wire logic   clock,
   input  wire logic   reset,
   ntcdiv_req_if.sink  req_bus,
   ntcdiv_rsp_if.source rsp_bus,
   ntcdiv_csr_if.sink  csr_bus
);

   localparam int AW = ntcdiv_pkg::ADC_W;
   localparam int RW = ntcdiv_pkg::RES_W;
   localparam int PW = ntcdiv_pkg::MUL_P_W;
   localparam int TW = ntcdiv_pkg::TEMP_W;

   ntcdiv_pkg::state_type state_ff, state_in;

   logic [ntcdiv_pkg::SUPPLY_W-1:0] supply_ff, supply_in;
   logic [ntcdiv_pkg::RS10_W-1:0]   rs10_ff, rs10_in;
   logic [ntcdiv_pkg::SUM_W-1:0]    sumf_ff, sumf_in;
   logic [ntcdiv_pkg::SUM_W-1:0]    suml_ff, suml_in;
   logic                            upper_ff, upper_in;
   logic [ntcdiv_pkg::RS10_W-1:0]   series_x10;

   logic [AW-1:0]  adc_ff, adc_in;
   logic [PW-1:0]  mul_p_ff;
   logic [PW-1:0]  lhs_ff, lhs_in;
   logic           above_ff, above_in;
   logic [RW-1:0]  res_ff, res_in;
   logic [RW-1:0]  prev_ff, prev_in;
   logic [RW-1:0]  den_ff, den_in;
   logic [RW-1:0]  numi_ff, numi_in;
   logic [ntcdiv_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic signed [TW-1:0] base_ff, base_in;
   logic signed [TW-1:0] temp_res_ff, temp_res_in;
   logic [ntcdiv_pkg::STATUS_W-1:0] status_res_ff, status_res_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [TW-1:0]            rsp_temp_ff, rsp_temp_in;
   logic [ntcdiv_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [ntcdiv_pkg::MUL_A_W-1:0] mul_a;
   logic [ntcdiv_pkg::MUL_B_W-1:0] mul_b;
   logic [ntcdiv_pkg::IDX_W-1:0]   rom_addr;
   logic [RW-1:0]                  rom_data;
   ntcdiv_pkg::div_cmd_type        div_cmd;
   ntcdiv_pkg::div_rsp_type        div_rsp;

   logic          below;
   logic          special;
   logic [RW-1:0] special_res;
   logic [AW-1:0] diff;
   logic [AW-1:0] dvs;
   logic          found;

   function automatic logic [RW-1:0] clamp_res(input logic [RW-1:0] r);
      logic [RW-1:0] c;
      if (r > ntcdiv_pkg::RES_FIRST) begin
         c = ntcdiv_pkg::RES_FIRST;
      end else if (r < ntcdiv_pkg::RES_LAST) begin
         c = ntcdiv_pkg::RES_LAST;
      end else begin
         c = r;
      end
      return c;
   endfunction

   ntcdiv_rom u_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   ntcdiv_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // register file
   assign csr_bus.ready = 1'b1;

   always_comb begin
      series_x10 = ntcdiv_pkg::RS10_W'({csr_bus.data, 3'b000})
                 + ntcdiv_pkg::RS10_W'({csr_bus.data, 1'b0});
      supply_in  = supply_ff;
      rs10_in    = rs10_ff;
      sumf_in    = sumf_ff;
      suml_in    = suml_ff;
      upper_in   = upper_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            ntcdiv_pkg::CSR_SUPPLY: begin
               supply_in = csr_bus.data[ntcdiv_pkg::SUPPLY_W-1:0];
            end
            ntcdiv_pkg::CSR_SERIES: begin
               rs10_in = series_x10;
               sumf_in = ntcdiv_pkg::SUM_W'(series_x10)
                       + ntcdiv_pkg::SUM_W'(ntcdiv_pkg::RES_FIRST);
               suml_in = ntcdiv_pkg::SUM_W'(series_x10)
                       + ntcdiv_pkg::SUM_W'(ntcdiv_pkg::RES_LAST);
            end
            ntcdiv_pkg::CSR_UPPER: begin
               upper_in = csr_bus.data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= ntcdiv_pkg::SUPPLY_RESET;
         rs10_ff   <= ntcdiv_pkg::RS10_RESET;
         sumf_ff   <= ntcdiv_pkg::SUMF_RESET;
         suml_ff   <= ntcdiv_pkg::SUML_RESET;
         upper_ff  <= 1'b0;
      end else begin
         supply_ff <= supply_in;
         rs10_ff   <= rs10_in;
         sumf_ff   <= sumf_in;
         suml_ff   <= suml_in;
         upper_ff  <= upper_in;
      end
   end

   // sequencer
   always_comb begin
      below = lhs_ff < mul_p_ff;
      diff  = upper_ff ? (supply_ff - adc_ff) : adc_ff;
      dvs   = upper_ff ? adc_ff : (supply_ff - adc_ff);
      found = (res_ff >= rom_data) || (idx_ff == ntcdiv_pkg::LAST_IDX);
      if (upper_ff) begin
         special     = (adc_ff == '0) || (adc_ff > supply_ff);
         special_res = (adc_ff == '0) ? ntcdiv_pkg::RES_FIRST : '0;
      end else begin
         special     = adc_ff >= supply_ff;
         special_res = ntcdiv_pkg::RES_FIRST;
      end

      state_in      = state_ff;
      adc_in        = adc_ff;
      lhs_in        = lhs_ff;
      above_in      = above_ff;
      res_in        = res_ff;
      prev_in       = prev_ff;
      den_in        = den_ff;
      numi_in       = numi_ff;
      idx_in        = idx_ff;
      base_in       = base_ff;
      temp_res_in   = temp_res_ff;
      status_res_in = status_res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_temp_in   = rsp_temp_ff;
      rsp_status_in = rsp_status_ff;
      mul_a         = '0;
      mul_b         = '0;
      rom_addr      = '0;
      div_cmd       = '0;
      req_bus.ready = 1'b0;

      unique case (state_ff)
         ntcdiv_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               adc_in   = req_bus.adc_mv;
               state_in = ntcdiv_pkg::ST_RC0;
            end
         end
         ntcdiv_pkg::ST_RC0: begin
            mul_a    = adc_ff;
            mul_b    = upper_ff ? suml_ff : sumf_ff;
            state_in = ntcdiv_pkg::ST_RC1;
         end
         ntcdiv_pkg::ST_RC1: begin
            lhs_in   = mul_p_ff;
            mul_a    = supply_ff;
            mul_b    = upper_ff ? ntcdiv_pkg::MUL_B_W'(rs10_ff)
                                : ntcdiv_pkg::MUL_B_W'(ntcdiv_pkg::RES_FIRST);
            state_in = ntcdiv_pkg::ST_RC2;
         end
         ntcdiv_pkg::ST_RC2: begin
            above_in = lhs_ff > mul_p_ff;
            mul_a    = adc_ff;
            mul_b    = upper_ff ? sumf_ff : suml_ff;
            state_in = ntcdiv_pkg::ST_RC3;
         end
         ntcdiv_pkg::ST_RC3: begin
            lhs_in   = mul_p_ff;
            mul_a    = supply_ff;
            mul_b    = upper_ff ? ntcdiv_pkg::MUL_B_W'(rs10_ff)
                                : ntcdiv_pkg::MUL_B_W'(ntcdiv_pkg::RES_LAST);
            state_in = ntcdiv_pkg::ST_RC4;
         end
         ntcdiv_pkg::ST_RC4: begin
            priority if (above_ff) begin
               temp_res_in   = '0;
               status_res_in = ntcdiv_pkg::STATUS_ABOVE;
               state_in      = ntcdiv_pkg::ST_OUT;
            end else if (below) begin
               temp_res_in   = '0;
               status_res_in = ntcdiv_pkg::STATUS_BELOW;
               state_in      = ntcdiv_pkg::ST_OUT;
            end else if (special) begin
               res_in   = clamp_res(special_res);
               state_in = ntcdiv_pkg::ST_WALK0;
            end else begin
               mul_a    = diff;
               mul_b    = ntcdiv_pkg::MUL_B_W'(rs10_ff);
               state_in = ntcdiv_pkg::ST_RES_DIV;
            end
         end
         ntcdiv_pkg::ST_RES_DIV: begin
            // quotient of 2^24 or more clamps to the first entry
            if (mul_p_ff[ntcdiv_pkg::DIV_NUM_W-1:RW] >= dvs) begin
               res_in   = ntcdiv_pkg::RES_FIRST;
               state_in = ntcdiv_pkg::ST_WALK0;
            end else begin
               div_cmd.start = 1'b1;
               div_cmd.steps = ntcdiv_pkg::RES_STEPS_CODE;
               div_cmd.num   = mul_p_ff[ntcdiv_pkg::DIV_NUM_W-1:0];
               div_cmd.den   = ntcdiv_pkg::DIV_DEN_W'(dvs);
               state_in      = ntcdiv_pkg::ST_RES_WAIT;
            end
         end
         ntcdiv_pkg::ST_RES_WAIT: begin
            if (div_rsp.done) begin
               res_in   = clamp_res(div_rsp.quo);
               state_in = ntcdiv_pkg::ST_WALK0;
            end
         end
         ntcdiv_pkg::ST_WALK0: begin
            prev_in  = rom_data;
            idx_in   = ntcdiv_pkg::IDX_W'(1);
            base_in  = ntcdiv_pkg::FIRST_CENTI;
            rom_addr = ntcdiv_pkg::IDX_W'(1);
            state_in = ntcdiv_pkg::ST_WALK;
         end
         ntcdiv_pkg::ST_WALK: begin
            if (found) begin
               den_in   = prev_ff - rom_data;
               numi_in  = prev_ff - res_ff;
               state_in = ntcdiv_pkg::ST_INT_MUL;
            end else begin
               prev_in  = rom_data;
               idx_in   = idx_ff + ntcdiv_pkg::IDX_W'(1);
               base_in  = base_ff + ntcdiv_pkg::STEP_CENTI;
               rom_addr = idx_ff + ntcdiv_pkg::IDX_W'(1);
            end
         end
         ntcdiv_pkg::ST_INT_MUL: begin
            mul_a    = ntcdiv_pkg::INT_SCALE;
            mul_b    = ntcdiv_pkg::MUL_B_W'(numi_ff);
            state_in = ntcdiv_pkg::ST_INT_DIV;
         end
         ntcdiv_pkg::ST_INT_DIV: begin
            // (1000*num + den) / (2*den), rounds half up
            div_cmd.start = 1'b1;
            div_cmd.steps = ntcdiv_pkg::INT_STEPS_CODE;
            div_cmd.num   = ntcdiv_pkg::DIV_NUM_W'(mul_p_ff)
                          + ntcdiv_pkg::DIV_NUM_W'(den_ff);
            div_cmd.den   = ntcdiv_pkg::DIV_DEN_W'({den_ff, 1'b0});
            state_in      = ntcdiv_pkg::ST_INT_WAIT;
         end
         ntcdiv_pkg::ST_INT_WAIT: begin
            if (div_rsp.done) begin
               temp_res_in   = base_ff
                             + TW'($signed({1'b0, div_rsp.quo[ntcdiv_pkg::INT_STEPS-1:0]}));
               status_res_in = ntcdiv_pkg::STATUS_OK;
               state_in      = ntcdiv_pkg::ST_OUT;
            end
         end
         ntcdiv_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_temp_in   = temp_res_ff;
               rsp_status_in = status_res_ff;
               state_in      = ntcdiv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ntcdiv_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ntcdiv_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_p_ff      <= PW'(mul_a) * PW'(mul_b);
      adc_ff        <= adc_in;
      lhs_ff        <= lhs_in;
      above_ff      <= above_in;
      res_ff        <= res_in;
      prev_ff       <= prev_in;
      den_ff        <= den_in;
      numi_ff       <= numi_in;
      idx_ff        <= idx_in;
      base_ff       <= base_in;
      temp_res_ff   <= temp_res_in;
      status_res_ff <= status_res_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.temp_centi_c = rsp_temp_ff;
   assign rsp_bus.status       = rsp_status_ff;

endmodule

`default_nettype wire

[rtl/ntcdiv_rom.sv]
// Resistance table ROM, registered read.
// Depends on ntcdiv_pkg.
`default_nettype none

module ntcdiv_rom (
   input  wire logic                         clock,
   input  wire logic [ntcdiv_pkg::IDX_W-1:0] rd_addr,
   output logic      [ntcdiv_pkg::RES_W-1:0] rd_data
);

   logic [ntcdiv_pkg::RES_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= ntcdiv_pkg::res_entry(rd_addr);
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/ntcdiv_div.sv]
// Restoring divider, one quotient bit per cycle, variable step count.
// Caller guarantees (num >> steps) < den. Depends on ntcdiv_pkg.
`default_nettype none

module ntcdiv_div (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ntcdiv_pkg::div_cmd_type cmd,
   output ntcdiv_pkg::div_rsp_type      rsp
);

   localparam int NW = ntcdiv_pkg::DIV_NUM_W;
   localparam int DW = ntcdiv_pkg::DIV_DEN_W;
   localparam int QW = ntcdiv_pkg::DIV_QUO_W;
   localparam int SW = ntcdiv_pkg::DIV_STEP_W;
   localparam int HW = ntcdiv_pkg::DIV_SH_W;

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [NW-1:0] bits_ff, bits_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [DW+1:0] trial;
   logic [HW-1:0] shamt;

   always_comb begin
      trial   = {1'b0, rem_ff, bits_ff[NW-1]} - {2'b00, den_ff};
      shamt   = HW'(NW) - HW'(cmd.steps);
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      if (cmd.start) begin
         run_in  = 1'b1;
         cnt_in  = cmd.steps;
         rem_in  = DW'(cmd.num >> cmd.steps);
         den_in  = cmd.den;
         bits_in = cmd.num << shamt;
         quo_in  = '0;
      end else if (run_ff) begin
         if (!trial[DW+1]) begin
            rem_in = trial[DW-1:0];
         end else begin
            rem_in = {rem_ff[DW-2:0], bits_ff[NW-1]};
         end
         quo_in  = {quo_ff[QW-2:0], ~trial[DW+1]};
         bits_in = {bits_ff[NW-2:0], 1'b0};
         cnt_in  = cnt_ff - SW'(1);
         if (cnt_ff == SW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

`default_nettype wire

[rtl/ntcdiv_checker.sv]
// Port-level assertions for ntc_divider_lut_temperature and their bind.
// Depends on ntcdiv_pkg and the top level.
`default_nettype none

module ntcdiv_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_valid,
   input wire logic                                   req_ready,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_ready,
   input wire logic signed [ntcdiv_pkg::TEMP_W-1:0]   rsp_temp,
   input wire logic        [ntcdiv_pkg::STATUS_W-1:0] rsp_status
);

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ntcdiv_pkg::STATUS_OK)
                 || (rsp_status == ntcdiv_pkg::STATUS_ABOVE)
                 || (rsp_status == ntcdiv_pkg::STATUS_BELOW))
      else $error("result status code undefined");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ntcdiv_pkg::STATUS_OK) |-> rsp_temp == '0)
      else $error("flagged result carries nonzero temperature");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ntcdiv_pkg::STATUS_OK)
         |-> (rsp_temp >= ntcdiv_pkg::TEMP_MIN) && (rsp_temp <= ntcdiv_pkg::TEMP_MAX))
      else $error("temperature outside table span");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second reading taken while one is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_temp) && $stable(rsp_status))
      else $error("stalled result beat changed");

endmodule

bind ntc_divider_lut_temperature ntcdiv_checker u_ntcdiv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_temp   (rsp_bus.temp_centi_c),
   .rsp_status (rsp_bus.status)
);

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for ntc_divider_lut_temperature: drives ADC readings
// and register writes over valid/ready channels and checks each result beat
// against an in-bench predictor. Depends on ntcdiv_pkg, ntcdiv_ifs and the top level.
`timescale 1ns / 100ps

module testbench;

   localparam int ADC_MAX     = (1 << ntcdiv_pkg::ADC_W) - 1;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 400;
   localparam logic [ntcdiv_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // thermistor table, tenths of an ohm, -55 C upward in 5 C steps
   localparam longint unsigned NTC_DOHM [0:ntcdiv_pkg::FULL_TABLE-1] = '{
      9630000, 6701000, 4717000, 3365000, 2426000, 1770000, 1304000,
      970700, 729300, 553300, 423200, 326500, 253900, 199000,
      157100, 124900, 100000, 80570, 65310, 53270, 43690,
      36030, 29860, 24880, 20830, 17520, 14810, 12580,
      10720, 9177, 7885, 6800, 5886, 5112, 4454,
      3893, 3417, 3009, 2654, 2348, 2083, 1853,
      1653
   };

   typedef struct packed {
      logic signed [ntcdiv_pkg::TEMP_W-1:0] temp;
      logic [ntcdiv_pkg::STATUS_W-1:0]      status;
   } reading_result_type;

   logic clock = 1'b0;
   logic reset;

   ntcdiv_req_if req_bus ();
   ntcdiv_rsp_if rsp_bus ();
   ntcdiv_csr_if csr_bus ();

   ntc_divider_lut_temperature uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   logic [ntcdiv_pkg::SUPPLY_W-1:0] cfg_supply;
   logic [ntcdiv_pkg::SERIES_W-1:0] cfg_series;
   logic                            cfg_upper;

   logic [ntcdiv_pkg::ADC_W-1:0] adc_backlog [$];
   reading_result_type           expected_temps [$];
   int  readings_sent    = 0;
   int  readings_checked = 0;
   int  mismatches       = 0;
   int  cycle_count      = 0;
   bit  req_taken        = 1'b0;
   bit  jitter_on        = 1'b0;
   bit  stall_request    = 1'b0;
   bit  rsp_stall        = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic reading_result_type predict_reading(
      input logic [ntcdiv_pkg::ADC_W-1:0] adc_in);
      longint unsigned adc, sup, rs10, r0, rl, r, top, den, num, frac;
      bit above, below;
      int seg;
      reading_result_type res;
      adc  = adc_in;
      sup  = cfg_supply;
      rs10 = longint'(cfg_series) * 10;
      r0   = NTC_DOHM[0];
      rl   = NTC_DOHM[ntcdiv_pkg::USED_ENTRIES-1];
      res.temp   = '0;
      res.status = ntcdiv_pkg::STATUS_OK;
      if (cfg_upper) begin
         above = adc * (rl + rs10) > sup * rs10;
         below = adc * (r0 + rs10) < sup * rs10;
      end else begin
         above = adc * (r0 + rs10) > sup * r0;
         below = adc * (rl + rs10) < sup * rl;
      end
      if (above) begin
         res.status = ntcdiv_pkg::STATUS_ABOVE;
      end else if (below) begin
         res.status = ntcdiv_pkg::STATUS_BELOW;
      end else begin
         if (cfg_upper) begin
            if (adc == 0) r = r0;
            else if (adc > sup) r = 0;
            else r = rs10 * (sup - adc) / adc;
         end else begin
            if (adc >= sup) r = r0;
            else r = rs10 * adc / (sup - adc);
         end
         if (r > r0) r = r0;
         if (r < rl) r = rl;
         seg = 1;
         while (seg < ntcdiv_pkg::USED_ENTRIES - 1 && r < NTC_DOHM[seg]) seg++;
         top  = NTC_DOHM[seg-1];
         den  = top - NTC_DOHM[seg];
         num  = top - r;
         frac = (1000 * num + den) / (2 * den);
         res.temp = ntcdiv_pkg::TEMP_W'((-55 + 5 * (seg - 1)) * 100 + int'(frac));
      end
      return res;
   endfunction

   // lowest and highest in-range reading for the current settings, -1 if none
   task automatic find_valid_band(output int lo, output int hi);
      reading_result_type res;
      lo = -1;
      hi = -1;
      for (int a = 0; a <= ADC_MAX; a++) begin
         res = predict_reading(ntcdiv_pkg::ADC_W'(a));
         if (res.status == ntcdiv_pkg::STATUS_OK) begin
            if (lo < 0) lo = a;
            hi = a;
         end
      end
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid  <= 1'b0;
         req_bus.adc_mv <= '0;
      end else if (!req_bus.valid || req_taken) begin
         if (adc_backlog.size() != 0 && !(jitter_on && $urandom_range(99) < 14)) begin
            req_bus.valid  <= 1'b1;
            req_bus.adc_mv <= adc_backlog.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      rsp_bus.ready <= !rsp_stall && !(jitter_on && $urandom_range(99) < 14);
   end

   // long receiver hold-off, counted here
   initial begin
      wait (stall_request);
      @(posedge clock);
      rsp_stall = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_stall = 1'b0;
   end

   // accepted readings
   always @(posedge clock) begin
      req_taken = !reset && req_bus.valid && req_bus.ready;
      if (req_taken) expected_temps.push_back(predict_reading(req_bus.adc_mv));
   end

   // result beats
   always @(posedge clock) begin
      reading_result_type exp_res;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_temps.size() == 0) begin
            $error("unexpected result beat: temp_centi_c %0d status %0d",
                   rsp_bus.temp_centi_c, rsp_bus.status);
            mismatches++;
         end else begin
            exp_res = expected_temps.pop_front();
            if (rsp_bus.temp_centi_c !== exp_res.temp) begin
               $error("temp_centi_c: expected %0d, actual %0d",
                      $signed(exp_res.temp), rsp_bus.temp_centi_c);
               mismatches++;
            end
            if (rsp_bus.status !== exp_res.status) begin
               $error("status: expected %0d, actual %0d", exp_res.status, rsp_bus.status);
               mismatches++;
            end
            readings_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic void queue_reading(input int v);
      if (v < 0) v = 0;
      if (v > ADC_MAX) v = ADC_MAX;
      adc_backlog.push_back(ntcdiv_pkg::ADC_W'(v));
      readings_sent++;
   endfunction

   task automatic wait_drained();
      while (readings_checked != readings_sent) @(negedge clock);
   endtask

   task automatic write_register(input logic [ntcdiv_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [ntcdiv_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      unique case (idx)
         ntcdiv_pkg::CSR_SUPPLY: cfg_supply = value[ntcdiv_pkg::SUPPLY_W-1:0];
         ntcdiv_pkg::CSR_SERIES: cfg_series = value[ntcdiv_pkg::SERIES_W-1:0];
         ntcdiv_pkg::CSR_UPPER:  cfg_upper  = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_config(input int supply, input int series, input bit upper);
      write_register(ntcdiv_pkg::CSR_SUPPLY, ntcdiv_pkg::CSR_DATA_W'(supply));
      write_register(ntcdiv_pkg::CSR_SERIES, ntcdiv_pkg::CSR_DATA_W'(series));
      write_register(ntcdiv_pkg::CSR_UPPER, ntcdiv_pkg::CSR_DATA_W'(upper));
   endtask

   // ADC range ends and band edges first, then readings weighted toward the valid band
   task automatic run_phase(input int count, input bit steady);
      int lo, hi, pick, v;
      find_valid_band(lo, hi);
      @(posedge clock);
      jitter_on = !steady;
      queue_reading(0);
      queue_reading(ADC_MAX);
      if (lo >= 0) begin
         if (lo > 0) queue_reading(lo - 1);
         queue_reading(lo);
         queue_reading(hi);
         if (hi < ADC_MAX) queue_reading(hi + 1);
      end
      repeat (count) begin
         pick = $urandom_range(99);
         if (lo >= 0 && pick < 60) v = $urandom_range(hi, lo);
         else if (lo >= 0 && pick < 75)
            v = ($urandom_range(1) ? lo : hi) + int'($urandom_range(6)) - 3;
         else v = $urandom_range(ADC_MAX);
         queue_reading(v);
      end
      wait_drained();
   endtask

   task automatic random_config();
      int w;
      w = $urandom_range(ntcdiv_pkg::SERIES_W, 1);
      set_config($urandom_range(ADC_MAX, 1),
                 $urandom_range((1 << w) - 1, 1 << (w - 1)),
                 $urandom_range(1));
   endtask

   initial begin
      reset          = 1'b1;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = '0;
      csr_bus.data   = '0;
      cfg_supply     = ntcdiv_pkg::SUPPLY_W'(3000);
      cfg_series     = ntcdiv_pkg::SERIES_W'(10000);
      cfg_upper      = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: divider midpoint lands exactly on the 25 C entry
      @(posedge clock);
      queue_reading(1);
      queue_reading(1500);
      queue_reading(2999);
      queue_reading(3000);
      queue_reading(3001);
      queue_reading(4096);
      queue_reading('h1555);
      queue_reading('h0AAA);
      run_phase(0, 1'b0);

      // write to a missing register must not disturb the settings
      write_register(CSR_UNUSED, '1);
      run_phase(30, 1'b0);

      // supply write with upper bits set; only the low 13 bits count
      write_register(ntcdiv_pkg::CSR_SUPPLY, '1);
      write_register(ntcdiv_pkg::CSR_SERIES, ntcdiv_pkg::CSR_DATA_W'(1000000));
      write_register(ntcdiv_pkg::CSR_UPPER, ntcdiv_pkg::CSR_DATA_W'(1));
      run_phase(40, 1'b0);

      set_config(1, 1, 1'b0);
      run_phase(30, 1'b0);
      set_config(0, 0, 1'b1);
      run_phase(15, 1'b0);
      set_config(5000, 0, 1'b0);
      run_phase(15, 1'b0);
      set_config(ADC_MAX, (1 << ntcdiv_pkg::SERIES_W) - 1, 1'b0);
      run_phase(30, 1'b0);
      set_config(1, 1, 1'b1);
      run_phase(20, 1'b0);

      set_config(3300, 10000, 1'b1);
      stall_request = 1'b1;
      run_phase(60, 1'b0);

      random_config();
      run_phase(60, 1'b1);
      repeat (5) begin
         random_config();
         run_phase(20, 1'b0);
      end

      set_config(3000, 10000, 1'b0);
      run_phase(40, 1'b0);

      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_temps.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/ntcdiv_pkg.sv
rtl/ntcdiv_ifs.sv
rtl/ntcdiv_rom.sv
rtl/ntcdiv_div.sv
rtl/ntc_divider_lut_temperature.sv
rtl/ntcdiv_checker.sv
dv/testbench.sv
